// ===== sv/opbm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the outer-product tile multiply-accumulate.
// No dependencies.
package opbm_pkg;

  localparam int DATA_W = 16;
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = 48;
  localparam int IDX_W  = 2;

  localparam int TILE_ROWS_DEF = 4;
  localparam int TILE_COLS_DEF = 4;
  localparam int LANES         = 4;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [IDX_W-1:0]         idx_t;

  typedef enum logic [1:0] {
    ACT_PRESET = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_DRAIN  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // Per-cell control, driven by the top level each cycle.
  typedef struct packed {
    logic upd;     // capture a*b for accumulation next cycle
    logic preset;  // load preset value
    logic shift;   // take neighbor's accumulator (ring rotate)
  } cell_ctrl_t;

endpackage

// ===== sv/opbm_cell.sv =====
`timescale 1ns / 1ps
// One accumulator cell: multiply stage, saturating 48-bit accumulate,
// and a shift path to its neighbor in the drain ring. Uses opbm_pkg.
module opbm_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  opbm_pkg::cell_ctrl_t ctrl,
  input  opbm_pkg::data_t     a,
  input  opbm_pkg::data_t     b,
  input  opbm_pkg::acc_t      preset_value,
  input  opbm_pkg::acc_t      shift_in,
  output opbm_pkg::acc_t      acc
);
  import opbm_pkg::*;

  prod_t prod_r;
  logic  prod_vld_r;
  acc_t  acc_r;
  acc_t  acc_nxt;
  logic signed [ACC_W:0] sum;

  always_ff @(posedge clk) begin
    if (ctrl.upd) begin
      prod_r <= a * b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctrl.upd;
    end
  end

  always_comb begin
    sum = {acc_r[ACC_W-1], acc_r} + {{(ACC_W+1-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    acc_nxt = acc_r;
    if (ctrl.shift) begin
      acc_nxt = shift_in;
    end else if (ctrl.preset) begin
      acc_nxt = preset_value;
    end else if (prod_vld_r) begin
      if (sum[ACC_W] != sum[ACC_W-1]) begin
        acc_nxt = sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
        acc_nxt = sum[ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// ===== sv/outer_product_block_matmul.sv =====
`timescale 1ns / 1ps
// Top level: a ring of TILE_ROWS x TILE_COLS accumulator cells plus the drain
// sequencer. Uses opbm_pkg and opbm_cell.
//
// Usage:
//   Input beats are taken at a rising edge with start high and busy low.
//   in_action selects preset (load one accumulator from in_preset_value at
//   in_preset_row/in_preset_col; out-of-tile positions are dropped), rank-one
//   update (every cell adds in_a_row[r] * in_b_col[c], saturating to 48 bits),
//   or drain. Code 3 is dropped.
//   Presets and updates are taken one per cycle, back to back; busy stays low.
//   Each cell registers its product, then accumulates on the next edge.
//   A drain raises busy while the sequencer walks every cell once. The ring
//   rotates one cell per cycle past its head; the first result reaches the
//   ports through the drain flag register and then the output register, and
//   one follows in every cycle, row-major, with out_last on the final one.
//   After a full turn every cell holds its own value again, so a drain leaves
//   the tile unchanged.
//   The drain rate is set by the single head tap of the rotating ring.
//   Results show for one cycle under out_strobe; the receiver cannot stall.
//   Reset (rst_n low, synchronous) zeroes all accumulators and aborts a drain.
module outer_product_block_matmul #(
  parameter int TILE_ROWS = opbm_pkg::TILE_ROWS_DEF,
  parameter int TILE_COLS = opbm_pkg::TILE_COLS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_action,
  input  opbm_pkg::data_t     in_a_row0,
  input  opbm_pkg::data_t     in_a_row1,
  input  opbm_pkg::data_t     in_a_row2,
  input  opbm_pkg::data_t     in_a_row3,
  input  opbm_pkg::data_t     in_b_col0,
  input  opbm_pkg::data_t     in_b_col1,
  input  opbm_pkg::data_t     in_b_col2,
  input  opbm_pkg::data_t     in_b_col3,
  input  opbm_pkg::idx_t      in_preset_row,
  input  opbm_pkg::idx_t      in_preset_col,
  input  opbm_pkg::acc_t      in_preset_value,
  output logic                out_strobe,
  output opbm_pkg::idx_t      out_row,
  output opbm_pkg::idx_t      out_col,
  output opbm_pkg::acc_t      out_value,
  output logic                out_last
);
  import opbm_pkg::*;

  localparam int NCELL = TILE_ROWS * TILE_COLS;

  data_t a_vec [LANES];
  data_t b_vec [LANES];
  acc_t  acc   [NCELL];

  logic    accept;
  action_t act;
  logic    drain_r, drain_nxt;
  idx_t    row_r, row_nxt;
  idx_t    col_r, col_nxt;
  logic    at_end;

  logic  out_strobe_r;
  logic  out_last_r;
  idx_t  out_row_r;
  idx_t  out_col_r;
  acc_t  out_value_r;

  assign a_vec[0] = in_a_row0;
  assign a_vec[1] = in_a_row1;
  assign a_vec[2] = in_a_row2;
  assign a_vec[3] = in_a_row3;
  assign b_vec[0] = in_b_col0;
  assign b_vec[1] = in_b_col1;
  assign b_vec[2] = in_b_col2;
  assign b_vec[3] = in_b_col3;

  assign accept = start && !busy;
  assign act    = action_t'(in_action);
  assign at_end = (row_r == IDX_W'(TILE_ROWS - 1)) && (col_r == IDX_W'(TILE_COLS - 1));

  for (genvar r = 0; r < TILE_ROWS; r++) begin : g_row
    for (genvar c = 0; c < TILE_COLS; c++) begin : g_col
      cell_ctrl_t ctrl;

      always_comb begin
        ctrl.upd    = accept && (act == ACT_UPDATE);
        ctrl.preset = accept && (act == ACT_PRESET) &&
                      (in_preset_row == IDX_W'(r)) && (in_preset_col == IDX_W'(c));
        ctrl.shift  = drain_r;
      end

      opbm_cell u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .a            (a_vec[r]),
        .b            (b_vec[c]),
        .preset_value (in_preset_value),
        .shift_in     (acc[(r * TILE_COLS + c + 1) % NCELL]),
        .acc          (acc[r * TILE_COLS + c])
      );
    end
  end

  // Drain sequencer: walk row/col alongside the ring rotation.
  always_comb begin
    drain_nxt = drain_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    if (drain_r) begin
      if (at_end) begin
        drain_nxt = 1'b0;
        row_nxt   = '0;
        col_nxt   = '0;
      end else if (col_r == IDX_W'(TILE_COLS - 1)) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end else if (accept && (act == ACT_DRAIN)) begin
      drain_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_r      <= 1'b0;
      row_r        <= '0;
      col_r        <= '0;
      out_strobe_r <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      drain_r      <= drain_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      out_strobe_r <= drain_r;
      out_last_r   <= drain_r && at_end;
    end
  end

  // Capture the ring head as it passes.
  always_ff @(posedge clk) begin
    if (drain_r) begin
      out_row_r   <= row_r;
      out_col_r   <= col_r;
      out_value_r <= acc[0];
    end
  end

  assign busy       = drain_r;
  assign out_strobe = out_strobe_r;
  assign out_last   = out_last_r;
  assign out_row    = out_row_r;
  assign out_col    = out_col_r;
  assign out_value  = out_value_r;

endmodule

// ===== sv/opbm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for outer_product_block_matmul, attached by bind.
// Uses opbm_pkg.
module opbm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_action,
  input logic       out_strobe,
  input logic       out_last
);
  import opbm_pkg::*;

  // A taken drain beat holds off the next beat.
  a_drain_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_action == ACT_DRAIN) |=> busy)
    else $error("drain beat did not raise busy");

  // Results of a drain come in an unbroken run.
  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe)
    else $error("gap inside a drain run");

  // busy drops exactly with the final result.
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_last)
    else $error("busy dropped without last result");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_strobe && !busy)
    else $error("last flag outside a result beat");

endmodule

bind outer_product_block_matmul opbm_checker u_opbm_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for outer_product_block_matmul: a directed table, then random beats,
// each drain result checked against a local 4x4 Q17.30 saturating accumulator tile.
// Depends on opbm_pkg and the outer_product_block_matmul RTL.
module testbench;
  import opbm_pkg::*;

  localparam int TILE     = 4;
  localparam int N_RANDOM = 290;
  localparam int LIMIT    = 200000;
  localparam int MAX_MSGS = 30;

  typedef struct {
    action_t action;
    data_t   a [TILE];
    data_t   b [TILE];
    idx_t    prow;
    idx_t    pcol;
    acc_t    pval;
  } beat_t;

  // Directed row: optional hand-typed value that every cell of a drain must show.
  typedef struct {
    beat_t beat;
    logic  has_known;
    acc_t  known;
  } dir_row_t;

  typedef struct {
    idx_t row;
    idx_t col;
    acc_t value;
    logic last;
  } tile_out_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_action;
  data_t in_a_row0, in_a_row1, in_a_row2, in_a_row3;
  data_t in_b_col0, in_b_col1, in_b_col2, in_b_col3;
  idx_t  in_preset_row, in_preset_col;
  acc_t  in_preset_value;
  logic  out_strobe;
  idx_t  out_row, out_col;
  acc_t  out_value;
  logic  out_last;

  acc_t      tile_model [TILE][TILE];
  tile_out_t drain_q [$];
  dir_row_t  dir_tab [$];
  int        n_err = 0;
  int        cycle = 0;

  outer_product_block_matmul u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_a_row0      (in_a_row0),
    .in_a_row1      (in_a_row1),
    .in_a_row2      (in_a_row2),
    .in_a_row3      (in_a_row3),
    .in_b_col0      (in_b_col0),
    .in_b_col1      (in_b_col1),
    .in_b_col2      (in_b_col2),
    .in_b_col3      (in_b_col3),
    .in_preset_row  (in_preset_row),
    .in_preset_col  (in_preset_col),
    .in_preset_value(in_preset_value),
    .out_strobe     (out_strobe),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_value      (out_value),
    .out_last       (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly random 16-bit values, with the corners mixed in.
  function automatic data_t rand_q15();
    case ($urandom_range(0, 11))
      0: return data_t'(16'sh8000);
      1: return data_t'(16'sh7fff);
      2: return data_t'(16'sh0000);
      3: return data_t'(16'shffff);
      default: return data_t'($urandom);
    endcase
  endfunction

  function automatic acc_t rand_acc();
    case ($urandom_range(0, 3))
      0: return ACC_MAX - acc_t'($urandom_range(0, 1 << 24));
      1: return ACC_MIN + acc_t'($urandom_range(0, 1 << 24));
      default: return acc_t'({$urandom, $urandom});
    endcase
  endfunction

  function automatic beat_t rand_beat();
    beat_t bt;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) bt.action = ACT_UPDATE;
    else if (pick < 80) bt.action = ACT_PRESET;
    else if (pick < 92) bt.action = ACT_DRAIN;
    else bt.action = ACT_NONE;
    for (int i = 0; i < TILE; i++) begin
      bt.a[i] = rand_q15();
      bt.b[i] = rand_q15();
    end
    bt.prow = idx_t'($urandom_range(0, 3));
    bt.pcol = idx_t'($urandom_range(0, 3));
    bt.pval = rand_acc();
    return bt;
  endfunction

  function automatic beat_t mk_beat(action_t act, int a0, int a1, int a2, int a3,
                                    int b0, int b1, int b2, int b3,
                                    int pr, int pc, acc_t pv);
    beat_t bt;
    bt.action = act;
    bt.a[0] = data_t'(a0); bt.a[1] = data_t'(a1); bt.a[2] = data_t'(a2); bt.a[3] = data_t'(a3);
    bt.b[0] = data_t'(b0); bt.b[1] = data_t'(b1); bt.b[2] = data_t'(b2); bt.b[3] = data_t'(b3);
    bt.prow = idx_t'(pr);
    bt.pcol = idx_t'(pc);
    bt.pval = pv;
    return bt;
  endfunction

  function automatic void add_row(beat_t bt, logic has_known = 1'b0, acc_t known = '0);
    dir_row_t row;
    row.beat      = bt;
    row.has_known = has_known;
    row.known     = known;
    dir_tab.push_back(row);
  endfunction

  // Advance the tile by one accepted beat; queue what a drain must emit.
  function automatic void apply_beat(beat_t bt, logic has_known, acc_t known);
    longint    sum;
    tile_out_t res;
    case (bt.action)
      ACT_PRESET: begin
        if (int'(bt.prow) < TILE && int'(bt.pcol) < TILE) tile_model[bt.prow][bt.pcol] = bt.pval;
      end
      ACT_UPDATE: begin
        for (int r = 0; r < TILE; r++) begin
          for (int c = 0; c < TILE; c++) begin
            sum = longint'(tile_model[r][c]) + longint'(bt.a[r]) * longint'(bt.b[c]);
            if (sum > longint'(ACC_MAX)) sum = longint'(ACC_MAX);
            else if (sum < longint'(ACC_MIN)) sum = longint'(ACC_MIN);
            tile_model[r][c] = acc_t'(sum);
          end
        end
      end
      ACT_DRAIN: begin
        for (int r = 0; r < TILE; r++) begin
          for (int c = 0; c < TILE; c++) begin
            res.row   = idx_t'(r);
            res.col   = idx_t'(c);
            res.value = has_known ? known : tile_model[r][c];
            res.last  = (r == TILE - 1) && (c == TILE - 1);
            drain_q.push_back(res);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Present a beat and hold it until taken; start stays high for a following beat.
  task automatic send(beat_t bt, logic has_known = 1'b0, acc_t known = '0);
    start           <= 1'b1;
    in_action       <= bt.action;
    in_a_row0       <= bt.a[0];
    in_a_row1       <= bt.a[1];
    in_a_row2       <= bt.a[2];
    in_a_row3       <= bt.a[3];
    in_b_col0       <= bt.b[0];
    in_b_col1       <= bt.b[1];
    in_b_col2       <= bt.b[2];
    in_b_col3       <= bt.b[3];
    in_preset_row   <= bt.prow;
    in_preset_col   <= bt.pcol;
    in_preset_value <= bt.pval;
    do @(posedge clk); while (busy !== 1'b0);
    apply_beat(bt, has_known, known);
  endtask

  task automatic idle_gap(logic no_gap);
    int n;
    int pick;
    pick = $urandom_range(0, 99);
    if (no_gap || pick < 45) n = 0;
    else if (pick < 80) n = $urandom_range(1, 3);
    else if (pick < 95) n = $urandom_range(4, 10);
    else n = $urandom_range(20, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic report(string what, longint exp_v, longint act_v);
    n_err++;
    if (n_err <= MAX_MSGS)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, what, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    tile_out_t exp_r;
    if (rst_n === 1'b1 && out_strobe !== 1'b0) begin
      if (drain_q.size() == 0) begin
        n_err++;
        if (n_err <= MAX_MSGS)
          $display("%0t: unexpected beat, expected none, actual row %0d col %0d value %0h",
                   $realtime, out_row, out_col, out_value);
      end else begin
        exp_r = drain_q.pop_front();
        if (out_row !== exp_r.row) report("row", exp_r.row, out_row);
        if (out_col !== exp_r.col) report("col", exp_r.col, out_col);
        if (out_value !== exp_r.value) report("value", exp_r.value, out_value);
        if (out_last !== exp_r.last) report("last", exp_r.last, out_last);
      end
    end
  end

  initial begin
    while (cycle < LIMIT) begin
      @(posedge clk);
      cycle++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    beat_t bt;
    int    n_items;
    logic  no_gap;
    logic  paused;

    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_action       <= ACT_NONE;
    in_a_row0       <= '0;
    in_a_row1       <= '0;
    in_a_row2       <= '0;
    in_a_row3       <= '0;
    in_b_col0       <= '0;
    in_b_col1       <= '0;
    in_b_col2       <= '0;
    in_b_col3       <= '0;
    in_preset_row   <= '0;
    in_preset_col   <= '0;
    in_preset_value <= '0;
    for (int r = 0; r < TILE; r++)
      for (int c = 0; c < TILE; c++) tile_model[r][c] = '0;

    // Fresh tile drains all zero.
    add_row(mk_beat(ACT_DRAIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0), 1'b1, '0);
    add_row(mk_beat(ACT_UPDATE, -32768, -32768, -32768, -32768,
                    -32768, -32768, -32768, -32768, 0, 0, '0));
    // Drain after an update, with or without an idle gap between them.
    add_row(mk_beat(ACT_DRAIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0));
    add_row(mk_beat(ACT_PRESET, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ACC_MAX));
    // Push the max cell past the top.
    add_row(mk_beat(ACT_UPDATE, 32767, 32767, 32767, 32767,
                    32767, 32767, 32767, 32767, 0, 0, '0));
    add_row(mk_beat(ACT_PRESET, 0, 0, 0, 0, 0, 0, 0, 0, 3, 3, ACC_MIN));
    add_row(mk_beat(ACT_PRESET, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3, ACC_MIN));
    // Push the min cells past the bottom.
    add_row(mk_beat(ACT_UPDATE, -32768, -32768, -32768, -32768,
                    32767, 32767, 32767, 32767, 0, 0, '0));
    add_row(mk_beat(ACT_PRESET, 0, 0, 0, 0, 0, 0, 0, 0, 3, 0, ACC_MAX));
    add_row(mk_beat(ACT_UPDATE, 0, 0, 0, -32768, -32768, 0, 0, 0, 0, 0, '0));
    // Unused action code with busy fields: must leave the tile alone.
    add_row(mk_beat(ACT_NONE, -1, 32767, -32768, 1, 5, -5, 77, -77,
                    1, 1, ACC_MAX));
    add_row(mk_beat(ACT_DRAIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0));
    // Second drain must repeat the first.
    add_row(mk_beat(ACT_DRAIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0));
    add_row(mk_beat(ACT_UPDATE, 1, -1, 32767, -32768, -32768, 32767, -1, 1, 0, 0, '0));
    // Preset after an update overwrites the updated cell.
    add_row(mk_beat(ACT_PRESET, 0, 0, 0, 0, 0, 0, 0, 0, 2, 1, 48'h5555_5555_5555));
    add_row(mk_beat(ACT_PRESET, 0, 0, 0, 0, 0, 0, 0, 0, 1, 2, 48'haaaa_aaaa_aaaa));
    add_row(mk_beat(ACT_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0));
    add_row(mk_beat(ACT_DRAIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0));
    add_row(mk_beat(ACT_PRESET, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0));
    add_row(mk_beat(ACT_DRAIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      idle_gap(1'b0);
      send(dir_tab[i].beat, dir_tab[i].has_known, dir_tab[i].known);
    end

    n_items = 0;
    no_gap  = 1'b0;
    paused  = 1'b0;
    while (n_items < N_RANDOM) begin
      if (n_items % 30 == 0) no_gap = ($urandom_range(0, 3) == 0);
      bt = rand_beat();
      idle_gap(no_gap);
      send(bt);
      n_items++;
      // Hold off once until the tile has fully drained.
      if (!paused && n_items == N_RANDOM / 2) begin
        paused = 1'b1;
        start <= 1'b0;
        while (drain_q.size() != 0) @(posedge clk);
      end
    end

    start <= 1'b0;
    while (drain_q.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (n_err == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
